@@ rtl/dnm_pkg.sv @@
// dnm_pkg: shared widths, register map, activation codes and the queue entry type
// of the dense neuron block, plus the elaboration-time functions that build the
// tanh, sigmoid and softplus lookup tables. No dependencies.
package dnm_pkg;

    // default table depth and fraction width
    localparam int ACT_TABLE_DEPTH_DEF = 256;
    localparam int FRAC_BITS_DEF       = 12;

    localparam int DATA_W  = 16;
    localparam int PROD_W  = 32;
    localparam int SUM_W   = 48;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN = -32768;

    // term queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // register indexes (paddr[2])
    localparam logic REG_ACT_KIND    = 1'b0;
    localparam logic REG_LEAKY_SLOPE = 1'b1;

    localparam logic [2:0]        ACT_KIND_RESET    = 3'd0;
    localparam logic signed [15:0] LEAKY_SLOPE_RESET = 16'sd410;

    // activation codes, 6 and 7 fall through to identity
    localparam logic [2:0] ACT_IDENTITY = 3'd0;
    localparam logic [2:0] ACT_RELU     = 3'd1;
    localparam logic [2:0] ACT_LEAKY    = 3'd2;
    localparam logic [2:0] ACT_TANH     = 3'd3;
    localparam logic [2:0] ACT_SIGMOID  = 3'd4;
    localparam logic [2:0] ACT_SOFTPLUS = 3'd5;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic signed [DATA_W-1:0] bias;
        logic                     first;
        logic                     last;
    } t_term;

    // ---------------- table generation, elaboration only ----------------
    localparam logic [63:0] QONE = 64'h0000_0000_8000_0000;

    // shift-subtract division
    function automatic logic [63:0] q_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (QONE >> 1)) >> 31;
    endfunction

    // e^(-a), Q.31
    function automatic logic [63:0] exp_neg(input logic [63:0] a);
        logic [63:0] r;
        logic [63:0] res;
        logic [63:0] term;
        r    = (a + 64'd16) >> 5;
        res  = QONE;
        term = QONE;
        if (r > QONE) begin
            r = QONE;
        end
        for (int k = 1; k <= 30; k++) begin
            if (term != 64'd0) begin
                term = q_udiv(q_mul(term, r), 64'(k));
                if ((k % 2) == 1) begin
                    res = (term > res) ? 64'd0 : res - term;
                end else begin
                    res = res + term;
                end
            end
        end
        for (int k = 0; k < 5; k++) begin
            res = q_mul(res, res);
        end
        return res;
    endfunction

    // ln(1 + t), Q.31
    function automatic logic [63:0] ln1p_q(input logic [63:0] t);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] acc;
        logic [63:0] p;
        z   = q_udiv(t << 31, (QONE << 1) + t);
        z2  = q_mul(z, z);
        acc = '0;
        p   = z;
        for (int k = 1; k < 80; k += 2) begin
            if (p != 64'd0) begin
                acc = acc + q_udiv(p, 64'(k));
                p   = q_mul(p, z2);
            end
        end
        return acc << 1;
    endfunction

    function automatic logic [15:0] q31_to_out(input logic signed [63:0] f, input int frac);
        logic [63:0]        mag;
        logic [63:0]        q;
        logic signed [63:0] s;
        mag = (f < 0) ? 64'(-f) : 64'(f);
        q   = (mag + (64'd1 << (30 - frac))) >> (31 - frac);
        if (q > 64'd65536) begin
            q = 64'd65536;
        end
        s = (f < 0) ? -$signed(q) : $signed(q);
        if (s > 64'sd32767) begin
            s = 64'sd32767;
        end
        if (s < -64'sd32768) begin
            s = -64'sd32768;
        end
        return s[15:0];
    endfunction

    function automatic logic [15:0] act_rom_entry(input logic [2:0] kind, input int idx,
                                                  input int depth, input int frac);
        logic signed [63:0] c;
        logic               neg;
        logic [63:0]        a;
        logic [63:0]        e1;
        logic [63:0]        e2;
        logic [63:0]        th;
        logic [63:0]        sg;
        logic [63:0]        sp;
        logic [15:0]        res;
        c   = $signed(q_udiv(64'(2 * idx + 1) << 34, 64'(depth))) - $signed(QONE << 3);
        neg = (c < 0);
        a   = neg ? 64'(-c) : 64'(c);
        res = '0;
        case (kind)
            ACT_TANH: begin
                e2  = exp_neg(a << 1);
                th  = q_udiv((QONE - e2) << 31, QONE + e2);
                res = q31_to_out(neg ? -$signed(th) : $signed(th), frac);
            end
            ACT_SIGMOID: begin
                e1  = exp_neg(a);
                sg  = q_udiv(QONE << 31, QONE + e1);
                if (neg) begin
                    sg = QONE - sg;
                end
                res = q31_to_out($signed(sg), frac);
            end
            ACT_SOFTPLUS: begin
                e1  = exp_neg(a);
                sp  = (neg ? 64'd0 : a) + ln1p_q(e1);
                res = q31_to_out($signed(sp), frac);
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

endpackage

@@ rtl/dnm_regs.sv @@
// dnm_regs: apb configuration registers (activation kind, leaky slope).
// Depends on dnm_pkg.
module dnm_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dnm_pkg::PADDR_W-1:0]       paddr,
    input  logic [dnm_pkg::APB_W-1:0]         pwdata,
    output logic [dnm_pkg::APB_W-1:0]         prdata,
    output logic                              pready,
    output logic [2:0]                        o_act_kind,
    output logic signed [dnm_pkg::DATA_W-1:0] o_leaky_slope
);

    logic                              w_wr;
    logic                              w_sel;
    logic [2:0]                        r_act_kind;
    logic signed [dnm_pkg::DATA_W-1:0] r_leaky_slope;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_sel  = paddr[dnm_pkg::PADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_kind    <= dnm_pkg::ACT_KIND_RESET;
            r_leaky_slope <= dnm_pkg::LEAKY_SLOPE_RESET;
        end else if (w_wr) begin
            case (w_sel)
                dnm_pkg::REG_ACT_KIND:    r_act_kind    <= pwdata[2:0];
                dnm_pkg::REG_LEAKY_SLOPE: r_leaky_slope <= signed'(pwdata[dnm_pkg::DATA_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_sel)
            dnm_pkg::REG_ACT_KIND:    prdata = dnm_pkg::APB_W'(r_act_kind);
            dnm_pkg::REG_LEAKY_SLOPE: prdata = dnm_pkg::APB_W'(r_leaky_slope);
            default:                  prdata = '0;
        endcase
    end

    assign o_act_kind    = r_act_kind;
    assign o_leaky_slope = r_leaky_slope;

endmodule

@@ rtl/dnm_front.sv @@
// dnm_front: takes input transactions, forms the feature*weight product and
// queues each term with its bias and first/last flags. Depends on dnm_pkg.
module dnm_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [47:0]             i_s_axis_tdata,  // feature, weight, bias
    input  logic                    i_s_axis_tuser,  // first_term
    input  logic                    i_s_axis_tlast,  // last_term
    output logic                    o_q_valid,
    output dnm_pkg::t_term          o_q_term,
    input  logic                    i_q_pop
);

    logic signed [dnm_pkg::DATA_W-1:0] w_feature;
    logic signed [dnm_pkg::DATA_W-1:0] w_weight;
    dnm_pkg::t_term                    w_term;
    logic                              w_push;

    dnm_pkg::t_term           r_mem [dnm_pkg::Q_DEPTH];
    logic [dnm_pkg::Q_AW-1:0] r_wr_ptr;
    logic [dnm_pkg::Q_AW-1:0] r_rd_ptr;
    logic [dnm_pkg::Q_AW:0]   r_count;
    logic [dnm_pkg::Q_AW:0]   n_count;

    assign w_feature   = signed'(i_s_axis_tdata[15:0]);
    assign w_weight    = signed'(i_s_axis_tdata[31:16]);
    assign w_term.prod = dnm_pkg::PROD_W'(w_feature) * dnm_pkg::PROD_W'(w_weight);
    assign w_term.bias = signed'(i_s_axis_tdata[47:32]);
    assign w_term.first = i_s_axis_tuser;
    assign w_term.last  = i_s_axis_tlast;

    assign o_s_axis_tready = (r_count != (dnm_pkg::Q_AW + 1)'(dnm_pkg::Q_DEPTH));
    assign w_push          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_q_valid       = (r_count != '0);
    assign o_q_term        = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_term;
        end
    end

endmodule

@@ rtl/dnm_back.sv @@
// dnm_back: accumulates queued terms, rounds and saturates the neuron sum,
// applies the selected activation and holds the result register. Depends on dnm_pkg.
module dnm_back #(
    parameter int ACT_TABLE_DEPTH = dnm_pkg::ACT_TABLE_DEPTH_DEF,
    parameter int FRAC_BITS       = dnm_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  dnm_pkg::t_term                    i_q_term,
    output logic                              o_q_pop,
    input  logic [2:0]                        i_act_kind,
    input  logic signed [dnm_pkg::DATA_W-1:0] i_leaky_slope,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [15:0]                       o_m_axis_tdata,  // neuron_out
    output logic                              o_m_axis_tuser   // saturated
);

    localparam int IW      = (ACT_TABLE_DEPTH > 1) ? $clog2(ACT_TABLE_DEPTH) : 1;
    localparam int SPAN    = 8 << FRAC_BITS;
    localparam int SUM_W   = dnm_pkg::SUM_W;
    localparam int PROD_W  = dnm_pkg::PROD_W;
    localparam int DATA_W  = dnm_pkg::DATA_W;

    // half lsb of the output, one bit above the accumulator so it cannot wrap
    localparam logic signed [SUM_W:0] RND_HALF = (SUM_W + 1)'(1) <<< (FRAC_BITS - 1);

    // lookup tables, constants built at elaboration
    logic [DATA_W-1:0] w_rom_tanh     [ACT_TABLE_DEPTH];
    logic [DATA_W-1:0] w_rom_sigmoid  [ACT_TABLE_DEPTH];
    logic [DATA_W-1:0] w_rom_softplus [ACT_TABLE_DEPTH];

    for (genvar g = 0; g < ACT_TABLE_DEPTH; g++) begin : g_rom
        localparam logic [DATA_W-1:0] L_TANH =
            dnm_pkg::act_rom_entry(dnm_pkg::ACT_TANH, g, ACT_TABLE_DEPTH, FRAC_BITS);
        localparam logic [DATA_W-1:0] L_SIGMOID =
            dnm_pkg::act_rom_entry(dnm_pkg::ACT_SIGMOID, g, ACT_TABLE_DEPTH, FRAC_BITS);
        localparam logic [DATA_W-1:0] L_SOFTPLUS =
            dnm_pkg::act_rom_entry(dnm_pkg::ACT_SOFTPLUS, g, ACT_TABLE_DEPTH, FRAC_BITS);
        assign w_rom_tanh[g]     = L_TANH;
        assign w_rom_sigmoid[g]  = L_SIGMOID;
        assign w_rom_softplus[g] = L_SOFTPLUS;
    end

    logic w_en;

    // accumulate stage
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] w_base;
    logic                    r_acc_last;

    // round stage
    logic signed [SUM_W:0]    w_rnd_sum;
    logic signed [SUM_W:0]    w_rnd_shr;
    logic signed [DATA_W-1:0] n_v;
    logic                     n_v_clip;
    logic signed [DATA_W-1:0] r_v;
    logic                     r_v_clip;
    logic                     r_v_vld;

    // activation stage
    logic signed [PROD_W-1:0] w_lk_prod;
    logic signed [PROD_W-1:0] w_lk_shr;
    logic signed [DATA_W-1:0] w_lk_val;
    logic                     w_lk_clip;
    logic signed [PROD_W-1:0] w_vx;
    logic signed [PROD_W-1:0] w_xc;
    logic [PROD_W-1:0]        w_u;
    logic [PROD_W-1:0]        w_scaled;
    logic [PROD_W-1:0]        w_idx_full;
    logic [IW-1:0]            w_rom_idx;
    logic [DATA_W-1:0]        n_out;
    logic                     n_sat;
    logic [DATA_W-1:0]        r_out_data;
    logic                     r_out_sat;
    logic                     r_out_vld;

    // the whole back pipeline moves together; it freezes only on output backpressure
    assign w_en    = !r_out_vld || i_m_axis_tready;
    assign o_q_pop = w_en && i_q_valid;

    assign w_base = i_q_term.first ? (SUM_W'(i_q_term.bias) <<< FRAC_BITS) : r_sum;
    assign n_sum  = w_base + SUM_W'(i_q_term.prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_acc_last <= 1'b0;
        end else if (w_en) begin
            if (o_q_pop) begin
                r_sum <= n_sum;
            end
            r_acc_last <= o_q_pop && i_q_term.last;
        end
    end

    // half-up rounding to q3.frac
    assign w_rnd_sum = (SUM_W + 1)'(r_sum) + RND_HALF;
    assign w_rnd_shr = w_rnd_sum >>> FRAC_BITS;

    always_comb begin
        n_v_clip = 1'b0;
        n_v      = w_rnd_shr[DATA_W-1:0];
        if (w_rnd_shr > (SUM_W + 1)'(dnm_pkg::OUT_MAX)) begin
            n_v      = DATA_W'(dnm_pkg::OUT_MAX);
            n_v_clip = 1'b1;
        end else if (w_rnd_shr < (SUM_W + 1)'(dnm_pkg::OUT_MIN)) begin
            n_v      = DATA_W'(dnm_pkg::OUT_MIN);
            n_v_clip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_vld <= 1'b0;
        end else if (w_en) begin
            r_v_vld <= r_acc_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v      <= n_v;
            r_v_clip <= n_v_clip;
        end
    end

    // leaky relu: floor of product / 2^frac, clipped
    assign w_lk_prod = PROD_W'(r_v) * PROD_W'(i_leaky_slope);
    assign w_lk_shr  = w_lk_prod >>> FRAC_BITS;

    always_comb begin
        w_lk_clip = 1'b0;
        w_lk_val  = w_lk_shr[DATA_W-1:0];
        if (w_lk_shr > PROD_W'(dnm_pkg::OUT_MAX)) begin
            w_lk_val  = DATA_W'(dnm_pkg::OUT_MAX);
            w_lk_clip = 1'b1;
        end else if (w_lk_shr < PROD_W'(dnm_pkg::OUT_MIN)) begin
            w_lk_val  = DATA_W'(dnm_pkg::OUT_MIN);
            w_lk_clip = 1'b1;
        end
    end

    // table index over the clamped range [-8, 8)
    assign w_vx = PROD_W'(r_v);

    always_comb begin
        w_xc = w_vx;
        if (w_vx < -PROD_W'(SPAN)) begin
            w_xc = -PROD_W'(SPAN);
        end else if (w_vx > PROD_W'(SPAN - 1)) begin
            w_xc = PROD_W'(SPAN - 1);
        end
    end

    assign w_u        = unsigned'(w_xc + PROD_W'(SPAN));
    assign w_scaled   = w_u * PROD_W'(ACT_TABLE_DEPTH);
    assign w_idx_full = w_scaled >> (FRAC_BITS + 4);
    assign w_rom_idx  = w_idx_full[IW-1:0];

    always_comb begin
        n_sat = r_v_clip;
        case (i_act_kind)
            dnm_pkg::ACT_RELU: begin
                n_out = (r_v < 0) ? '0 : unsigned'(r_v);
            end
            dnm_pkg::ACT_LEAKY: begin
                if (r_v < 0) begin
                    n_out = unsigned'(w_lk_val);
                    n_sat = r_v_clip || w_lk_clip;
                end else begin
                    n_out = unsigned'(r_v);
                end
            end
            dnm_pkg::ACT_TANH:     n_out = w_rom_tanh[w_rom_idx];
            dnm_pkg::ACT_SIGMOID:  n_out = w_rom_sigmoid[w_rom_idx];
            dnm_pkg::ACT_SOFTPLUS: n_out = w_rom_softplus[w_rom_idx];
            default:               n_out = unsigned'(r_v);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_v_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out;
            r_out_sat  <= n_sat;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_sat;

endmodule

@@ rtl/dense_neuron_mac_activation.sv @@
// dense_neuron_mac_activation: top level of the dense-layer neuron engine.
// Instantiates dnm_regs, dnm_front and dnm_back; depends on dnm_pkg.
//
// One feature/weight term is accepted per clock while the four-entry term queue
// has room; the single 16x16 multiplier in the front and the 48-bit accumulator
// in the back each handle one term per cycle, so sustained throughput is one
// term per cycle. The result closed by last_term passes the queue and the
// accumulate, round and activate stages into the output register. When the output
// is held off, the back pipeline freezes and the queue fills, after which tready
// drops. tanh, sigmoid and softplus use constant ACT_TABLE_DEPTH-entry tables over
// [-8, 8); there is no start-up pass. Configuration must be written by the
// user through the apb port only while the block is idle; it is not enforced.
module dense_neuron_mac_activation #(
    parameter int ACT_TABLE_DEPTH = dnm_pkg::ACT_TABLE_DEPTH_DEF,
    parameter int FRAC_BITS       = dnm_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [47:0]                 i_s_axis_tdata,  // feature, weight, bias
    input  logic                        i_s_axis_tuser,  // first_term
    input  logic                        i_s_axis_tlast,  // last_term
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [15:0]                 o_m_axis_tdata,  // neuron_out
    output logic                        o_m_axis_tuser,  // saturated
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dnm_pkg::PADDR_W-1:0] paddr,
    input  logic [dnm_pkg::APB_W-1:0]   pwdata,
    output logic [dnm_pkg::APB_W-1:0]   prdata,
    output logic                        pready
);

    logic [2:0]                        w_act_kind;
    logic signed [dnm_pkg::DATA_W-1:0] w_leaky_slope;
    logic                              w_q_valid;
    dnm_pkg::t_term                    w_q_term;
    logic                              w_q_pop;

    dnm_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_act_kind    (w_act_kind),
        .o_leaky_slope (w_leaky_slope)
    );

    dnm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_q_valid       (w_q_valid),
        .o_q_term        (w_q_term),
        .i_q_pop         (w_q_pop)
    );

    dnm_back #(
        .ACT_TABLE_DEPTH (ACT_TABLE_DEPTH),
        .FRAC_BITS       (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_term        (w_q_term),
        .o_q_pop         (w_q_pop),
        .i_act_kind      (w_act_kind),
        .i_leaky_slope   (w_leaky_slope),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

@@ rtl/dnm_checker.sv @@
// dnm_checker: port-level assertions for dense_neuron_mac_activation, bound to
// the top level below. Depends on dnm_pkg.
module dnm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tready,
    input logic                        i_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [15:0]                 i_m_axis_tdata,
    input logic                        i_m_axis_tuser,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [dnm_pkg::PADDR_W-1:0] paddr,
    input logic [dnm_pkg::APB_W-1:0]   pwdata,
    input logic [dnm_pkg::APB_W-1:0]   prdata,
    input logic                        pready
);

    // a held result keeps its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser))
        else $error("result changed while stalled");

    // reset empties the pipeline and the term queue
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_axis_tvalid && i_s_axis_tready)
        else $error("block not empty after reset");

    // activation kind reads back what was written
    a_kind_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready &&
        (paddr[dnm_pkg::PADDR_W-1] == dnm_pkg::REG_ACT_KIND) |=>
            !(paddr[dnm_pkg::PADDR_W-1] == dnm_pkg::REG_ACT_KIND) ||
            (prdata[2:0] == $past(pwdata[2:0])))
        else $error("activation kind readback mismatch");

    // slope reads back what was written
    a_slope_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready &&
        (paddr[dnm_pkg::PADDR_W-1] == dnm_pkg::REG_LEAKY_SLOPE) |=>
            !(paddr[dnm_pkg::PADDR_W-1] == dnm_pkg::REG_LEAKY_SLOPE) ||
            (prdata[15:0] == $past(pwdata[15:0])))
        else $error("leaky slope readback mismatch");

endmodule

bind dense_neuron_mac_activation dnm_checker u_dnm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
);
